[rtl/cibb_pkg.sv]
`timescale 1ns / 1ps

package cibb_pkg;

  localparam int unsigned SIDE    = 28;
  localparam int unsigned DEPTH   = SIDE * SIDE;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned COORD_W = 5;
  localparam int unsigned PIX_W   = 8;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PIX_W-1:0]   pix_t;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  function automatic addr_t pix_addr(input coord_t r, input coord_t c);
    addr_t row_base;
    row_base = ADDR_W'(r) * ADDR_W'(SIDE);
    return row_base + ADDR_W'(c);
  endfunction

endpackage

[rtl/center_image_by_bounding_box.sv]
`timescale 1ns / 1ps

// Holds one 28 x 28 image of 8-bit pixels in a single-port memory and tracks the bounding
// box of the nonzero pixels written since the last start transfer. A read transfer returns
// the pixel of the image recentered on that box, with everything outside the box reading as
// zero, and flags whether centering shifted the image. Every position must be written after
// a start before it is read. The block takes one item per cycle while in_stall_o is low; the
// single memory port sets that figure. A read result is held in the memory stage s1, then in
// the output register, which lets items enter while a result waits, until a read fills s1.
module center_image_by_bounding_box
  import cibb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [PIX_W-1:0]   pixel_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   out_pixel_o,
  output logic               moved_o
);

  pix_t mem_q [DEPTH];
  pix_t rdata_q;

  coord_t box_top_q, box_top_d;
  coord_t box_left_q, box_left_d;
  coord_t box_bottom_q, box_bottom_d;
  coord_t box_right_q, box_right_d;
  logic   box_valid_q, box_valid_d;

  logic s1_valid_q, s1_valid_d;
  logic s1_zero_q, s1_zero_d;
  logic s1_moved_q, s1_moved_d;

  logic out_valid_q, out_valid_d;
  pix_t out_pixel_q, out_pixel_d;
  logic out_moved_q, out_moved_d;

  action_e act;
  logic    accept;
  logic    s1_adv;
  logic    in_range;
  logic    mem_we;
  logic    mem_re;
  addr_t   mem_addr;

  coord_t                 ext_r, ext_c;
  coord_t                 mar_r, mar_c;
  logic   [COORD_W:0]     end_r, end_c;
  coord_t                 src_r, src_c;
  logic                   in_box;
  logic                   rd_moved;

  localparam coord_t SideC = COORD_W'(SIDE);

  assign act      = action_e'(action_i);
  assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept   = in_valid_i && !in_stall_o;
  assign in_range = (row_i < SideC) && (col_i < SideC);

  always_comb begin
    ext_r    = box_bottom_q - box_top_q + COORD_W'(1);
    ext_c    = box_right_q - box_left_q + COORD_W'(1);
    mar_r    = (SideC - ext_r) >> 1;
    mar_c    = (SideC - ext_c) >> 1;
    end_r    = {1'b0, mar_r} + {1'b0, ext_r};
    end_c    = {1'b0, mar_c} + {1'b0, ext_c};
    in_box   = ({1'b0, row_i} < end_r) && (row_i >= mar_r) &&
               ({1'b0, col_i} < end_c) && (col_i >= mar_c);
    src_r    = row_i - mar_r + box_top_q;
    src_c    = col_i - mar_c + box_left_q;
    rd_moved = (mar_r != box_top_q) || (mar_c != box_left_q);
  end

  always_comb begin
    box_top_d    = box_top_q;
    box_left_d   = box_left_q;
    box_bottom_d = box_bottom_q;
    box_right_d  = box_right_q;
    box_valid_d  = box_valid_q;
    s1_valid_d   = s1_valid_q && !s1_adv;
    s1_zero_d    = s1_zero_q;
    s1_moved_d   = s1_moved_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = pix_addr(row_i, col_i);
    if (accept) begin
      unique case (act)
        ACT_START: begin
          box_top_d    = '0;
          box_left_d   = '0;
          box_bottom_d = '0;
          box_right_d  = '0;
          box_valid_d  = 1'b0;
        end
        ACT_WRITE: begin
          if (in_range) begin
            mem_we = 1'b1;
            if (pixel_i != '0) begin
              if (!box_valid_q) begin
                box_top_d    = row_i;
                box_bottom_d = row_i;
                box_left_d   = col_i;
                box_right_d  = col_i;
                box_valid_d  = 1'b1;
              end else begin
                if (row_i < box_top_q) box_top_d = row_i;
                if (row_i > box_bottom_q) box_bottom_d = row_i;
                if (col_i < box_left_q) box_left_d = col_i;
                if (col_i > box_right_q) box_right_d = col_i;
              end
            end
          end
        end
        ACT_READ: begin
          s1_valid_d = 1'b1;
          mem_re     = 1'b1;
          if (box_valid_q) begin
            mem_addr   = pix_addr(src_r, src_c);
            s1_zero_d  = !(in_range && in_box);
            s1_moved_d = rd_moved;
          end else begin
            s1_zero_d  = !in_range;
            s1_moved_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_pixel_d = out_pixel_q;
    out_moved_d = out_moved_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
      out_pixel_d = s1_zero_q ? '0 : rdata_q;
      out_moved_d = s1_moved_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= pixel_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_top_q    <= '0;
      box_left_q   <= '0;
      box_bottom_q <= '0;
      box_right_q  <= '0;
      box_valid_q  <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      box_top_q    <= box_top_d;
      box_left_q   <= box_left_d;
      box_bottom_q <= box_bottom_d;
      box_right_q  <= box_right_d;
      box_valid_q  <= box_valid_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_zero_q   <= s1_zero_d;
    s1_moved_q  <= s1_moved_d;
    out_pixel_q <= out_pixel_d;
    out_moved_q <= out_moved_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign moved_o     = out_moved_q;

  a_read_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && act == ACT_READ) |=> s1_valid_q)
    else $error("accepted read did not reach the memory stage");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_valid_q |-> (box_top_q <= box_bottom_q && box_left_q <= box_right_q &&
                     box_bottom_q < SideC && box_right_q < SideC))
    else $error("bounding box bounds out of order");

  a_empty_box_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !box_valid_q |-> (box_top_q == '0 && box_left_q == '0 &&
                      box_bottom_q == '0 && box_right_q == '0))
    else $error("empty bounding box holds stale bounds");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("memory stage result lost on its way to the output");

endmodule

[tb/center_image_checker.sv]
`timescale 1ns / 1ps

module center_image_checker
  import cibb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [PIX_W-1:0]   out_pixel_o,
  input  logic               moved_o,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 reads_checked_o
);

  localparam int SPAN = SIDE;

  typedef struct {
    coord_t row;
    coord_t col;
    pix_t   pixel;
    logic   moved;
  } centered_px_t;

  pix_t         image_mem [DEPTH];
  coord_t       box_top;
  coord_t       box_left;
  coord_t       box_bottom;
  coord_t       box_right;
  logic         box_seen;
  centered_px_t expected_px [$];
  int           fails = 0;
  int           checked = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk_i) begin : watch
    int           ri;
    int           ci;
    int           ext_r;
    int           ext_c;
    int           mar_r;
    int           mar_c;
    int           src;
    centered_px_t want;
    if (!rst_ni) begin
      foreach (image_mem[i]) image_mem[i] = '0;
      box_top    = '0;
      box_left   = '0;
      box_bottom = '0;
      box_right  = '0;
      box_seen   = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_px.size() == 0) begin
          report_mismatch($sformatf("result with no read waiting: pixel %0d moved %0b",
                                    out_pixel_o, moved_o));
        end else begin
          want = expected_px.pop_front();
          checked++;
          if (out_pixel_o !== want.pixel) begin
            report_mismatch($sformatf("read (%0d,%0d): pixel %0d, expected %0d",
                                      want.row, want.col, out_pixel_o, want.pixel));
          end
          if (moved_o !== want.moved) begin
            report_mismatch($sformatf("read (%0d,%0d): moved %0b, expected %0b",
                                      want.row, want.col, moved_o, want.moved));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        ri = int'(row_i);
        ci = int'(col_i);
        case (action_e'(action_i))
          ACT_START: begin
            foreach (image_mem[i]) image_mem[i] = '0;
            box_top    = '0;
            box_left   = '0;
            box_bottom = '0;
            box_right  = '0;
            box_seen   = 1'b0;
          end
          ACT_WRITE: begin
            if (ri < SPAN && ci < SPAN) begin
              image_mem[ri * SPAN + ci] = pixel_i;
              if (pixel_i != '0) begin
                if (!box_seen) begin
                  box_top    = row_i;
                  box_bottom = row_i;
                  box_left   = col_i;
                  box_right  = col_i;
                  box_seen   = 1'b1;
                end else begin
                  if (row_i < box_top) box_top = row_i;
                  if (row_i > box_bottom) box_bottom = row_i;
                  if (col_i < box_left) box_left = col_i;
                  if (col_i > box_right) box_right = col_i;
                end
              end
            end
          end
          ACT_READ: begin
            want.row   = row_i;
            want.col   = col_i;
            want.pixel = '0;
            want.moved = 1'b0;
            if (!box_seen) begin
              if (ri < SPAN && ci < SPAN) want.pixel = image_mem[ri * SPAN + ci];
            end else begin
              ext_r = int'(box_bottom) - int'(box_top) + 1;
              ext_c = int'(box_right) - int'(box_left) + 1;
              mar_r = (SPAN - ext_r) / 2;
              mar_c = (SPAN - ext_c) / 2;
              want.moved = (mar_r != int'(box_top)) || (mar_c != int'(box_left));
              if (ri < SPAN && ci < SPAN && ri >= mar_r && ri < mar_r + ext_r &&
                  ci >= mar_c && ci < mar_c + ext_c) begin
                src = (ri - mar_r + int'(box_top)) * SPAN + (ci - mar_c + int'(box_left));
                want.pixel = image_mem[src];
              end
            end
            expected_px.push_back(want);
          end
          default: ;
        endcase
      end
    end
    fail_count_o    <= fails;
    pending_o       <= expected_px.size();
    reads_checked_o <= checked;
  end

endmodule

[tb/center_image_by_bounding_box_tb.sv]
`timescale 1ns / 1ps

module center_image_by_bounding_box_tb
  import cibb_pkg::*;
();

  localparam int HOLD_CYCLES = 60;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [1:0]         action_i    = '0;
  logic [COORD_W-1:0] row_i       = '0;
  logic [COORD_W-1:0] col_i       = '0;
  logic [PIX_W-1:0]   pixel_i     = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [PIX_W-1:0]   out_pixel_o;
  logic               moved_o;

  int   phase         = 0;
  int   send_idle_pct = 7;
  logic press_armed   = 1'b0;
  logic press_done    = 1'b0;
  int   hold_left     = 0;
  int   useful_items  = 0;
  int   junk_items    = 0;
  int   images        = 0;
  int   fail_count;
  int   pending;
  int   reads_checked;

  center_image_by_bounding_box dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pixel_o (out_pixel_o),
    .moved_o     (moved_o)
  );

  center_image_checker centering_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .pixel_i         (pixel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_pixel_o     (out_pixel_o),
    .moved_o         (moved_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .reads_checked_o (reads_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("center_image_by_bounding_box regression: fail");
    $finish;
  end

  // The long hold lets reads pile up until the block stalls its input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (press_armed && !press_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      press_done  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < ((phase == 0) ? 66 : (phase == 1) ? 7 : 0));
    end
  end

  task automatic offer_item(input action_e act, input int r, input int c, input int v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    row_i      <= coord_t'(r);
    col_i      <= coord_t'(c);
    pixel_i    <= pix_t'(v);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (act == ACT_NONE || (act == ACT_WRITE && (r >= SIDE || c >= SIDE))) begin
      junk_items++;
    end else begin
      useful_items++;
    end
  endtask

  task automatic offer_junk();
    case ($urandom_range(2))
      0: offer_item(ACT_NONE, $urandom_range(31), $urandom_range(31), $urandom_range(255));
      1: offer_item(ACT_WRITE, $urandom_range(31, 28), $urandom_range(31),
                    $urandom_range(255));
      default: offer_item(ACT_WRITE, $urandom_range(27), $urandom_range(31, 28),
                          $urandom_range(255));
    endcase
  endtask

  function automatic int pick_pixel(input bit zero_img);
    int sel;
    sel = $urandom_range(9);
    if (zero_img || sel < 4) return 0;
    if (sel == 4) return 255;
    if (sel == 5) return 1;
    return $urandom_range(255, 1);
  endfunction

  initial begin : stimulus
    int h;
    int w;
    int r0;
    int c0;
    int mr;
    int mc;
    int r;
    int c;
    int k;
    int v;
    int sel;
    int n_ops;
    int fill;
    int drain;
    bit zero_img;
    bit broken;
    bit nonzero;
    bit pressure_used;
    pressure_used = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty image, single pixel, full-side box, ignored items.
    offer_item(ACT_READ, 31, 31, 255);
    offer_item(ACT_NONE, 0, 0, 0);
    offer_item(ACT_START, 0, 0, 0);
    offer_item(ACT_WRITE, 0, 0, 0);
    offer_item(ACT_READ, 0, 0, 0);
    offer_item(ACT_WRITE, 0, 0, 255);
    offer_item(ACT_READ, 13, 13, 0);
    offer_item(ACT_READ, 0, 0, 0);
    offer_item(ACT_WRITE, 27, 27, 1);
    offer_item(ACT_READ, 0, 0, 0);
    offer_item(ACT_READ, 27, 27, 0);
    offer_item(ACT_WRITE, 28, 5, 7);
    offer_item(ACT_WRITE, 5, 31, 7);
    offer_item(ACT_READ, 31, 0, 0);
    offer_item(ACT_WRITE, 27, 27, 0);
    offer_item(ACT_READ, 27, 27, 0);
    offer_item(ACT_START, 31, 31, 255);
    offer_item(ACT_WRITE, 14, 14, 128);
    offer_item(ACT_READ, 13, 13, 0);
    offer_item(ACT_READ, 14, 14, 0);
    offer_item(ACT_WRITE, 13, 13, 9);
    offer_item(ACT_READ, 13, 13, 0);
    offer_item(ACT_READ, 14, 14, 0);
    offer_item(ACT_NONE, 31, 31, 255);

    for (int p = 0; p < 3; p++) begin
      phase <= p;
      send_idle_pct = (p == 0) ? 7 : (p == 1) ? 66 : 0;
      while (useful_items < (p + 1) * 550 / 3) begin
        images++;
        offer_item(ACT_START, $urandom_range(31), $urandom_range(31), $urandom_range(255));
        sel = $urandom_range(15);
        if (sel == 0) begin
          h = SIDE;
          w = $urandom_range(2, 1);
        end else if (sel == 1) begin
          h = $urandom_range(2, 1);
          w = SIDE;
        end else begin
          h = $urandom_range(6, 1);
          w = $urandom_range(6, 1);
        end
        r0 = $urandom_range(SIDE - h);
        c0 = $urandom_range(SIDE - w);
        mr = (SIDE - h) / 2;
        mc = (SIDE - w) / 2;
        zero_img = ($urandom_range(9) == 0);
        broken   = ($urandom_range(9) == 0);
        fill     = broken ? $urandom_range(h * w - 1) : h * w;
        nonzero  = 1'b0;

        // The whole rectangle is written before any in-range read, so every
        // source pixel of the centered image is defined.
        for (k = 0; k < fill; k++) begin
          if ($urandom_range(9) == 0) offer_junk();
          v = pick_pixel(zero_img);
          nonzero |= (v != 0);
          offer_item(ACT_WRITE, r0 + k / w, c0 + k % w, v);
        end

        if (broken) begin
          repeat (2) offer_item(ACT_READ, $urandom_range(31, 28), $urandom_range(31),
                                $urandom_range(255));
        end else begin
          n_ops = $urandom_range(14, 4);
          if (p == 2 && !pressure_used && nonzero) begin
            press_armed   <= 1'b1;
            pressure_used = 1'b1;
            n_ops         = 30;
          end
          repeat (n_ops) begin
            sel = $urandom_range(9);
            if (sel == 0) begin
              offer_junk();
            end else if (sel < 3) begin
              v = pick_pixel(zero_img);
              nonzero |= (v != 0);
              offer_item(ACT_WRITE, r0 + $urandom_range(h - 1), c0 + $urandom_range(w - 1), v);
            end else begin
              if ($urandom_range(7) == 0) begin
                r = $urandom_range(31, 28);
                c = $urandom_range(31);
                if ($urandom_range(1)) begin
                  k = r;
                  r = c;
                  c = k;
                end
              end else if (!nonzero) begin
                r = r0 + $urandom_range(h - 1);
                c = c0 + $urandom_range(w - 1);
              end else if ($urandom_range(3) == 0) begin
                r = $urandom_range(SIDE - 1);
                c = $urandom_range(SIDE - 1);
              end else begin
                r = $urandom_range((mr + h + 1 > 31) ? 31 : mr + h + 1,
                                   (mr < 2) ? 0 : mr - 2);
                c = $urandom_range((mc + w + 1 > 31) ? 31 : mc + w + 1,
                                   (mc < 2) ? 0 : mc - 2);
              end
              offer_item(ACT_READ, r, c, $urandom_range(255));
            end
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);

    $display("Covered %0d images with %0d working items and %0d ignored items.",
             images, useful_items, junk_items);
    $display("Checked %0d centered reads across three idle mixes and a %0d-cycle output hold.",
             reads_checked, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("center_image_by_bounding_box regression: pass");
    end else begin
      if (pending != 0) $display("%0d centered reads never returned", pending);
      $display("center_image_by_bounding_box regression: fail");
    end
    $finish;
  end

endmodule
